// File: src/gi_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the grid interpolation weight unit.
package gi_pkg;

    localparam int GRID_POINTS = 256;
    localparam int IDX_W       = $clog2(GRID_POINTS);
    localparam int COUNT_W     = IDX_W + 1;
    localparam int COORD_W     = 32;
    localparam int FRAC_BITS   = 16;
    localparam int WEIGHT_W    = FRAC_BITS + 1;
    localparam int PADDR_W     = 3;
    localparam int PDATA_W     = 32;

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(1) << FRAC_BITS;
    localparam logic [COUNT_W-1:0]  COUNT_MAX  = COUNT_W'(GRID_POINTS);

    // input word opcodes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // interpolation modes
    localparam logic [1:0] INTERP_LINEAR  = 2'd0;
    localparam logic [1:0] INTERP_NEAREST = 2'd1;
    localparam logic [1:0] INTERP_PWC     = 2'd2;

    // register indexes
    localparam logic REG_INTERP_MODE = 1'b0;
    localparam logic REG_GRID_COUNT  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LD_READ,
        ST_LD_CHECK,
        ST_Q_START,
        ST_SR_ADDR,
        ST_SR_CMP,
        ST_RD_LEFT,
        ST_RD_RIGHT,
        ST_EVAL,
        ST_DIV,
        ST_DONE
    } state_t;

    // word carried from one divider cell to the next
    typedef struct packed {
        logic                 valid;
        logic [COORD_W-1:0]   rem;
        logic [COORD_W-1:0]   den;
        logic [FRAC_BITS-1:0] quo;
    } div_word_t;

endpackage

// File: src/grid_interpolation_weights_top.sv
`timescale 1ns / 1ps
// Grid interpolation weight unit: grid store, binary search and divider cell chain.
//
//  channel | handshake             | word
//  --------+-----------------------+--------------------------------------------
//  in      | in_valid / in_stall   | mode, point_index, coord
//  out     | out_valid / out_stall | left_index, right_index, weight, status
//  cfg     | APB psel/penable      | interp_mode @0x0, grid_count @0x4
//
// A load steps through accept, read of the previous point, check and write, and result.
// A query steps through accept and start, then the search steps on the grid RAM read port,
// each an address and a compare state (at most 8 steps for 256 points), two neighbor
// reads and an evaluate state, then 16 cells of the divider chain in linear mode, then
// the result; nearest and constant modes and a coordinate outside the span skip the chain.
// One word is in work at a time; in_stall is high from accept until the result moves to
// the output register, which may still wait on out_stall while the next word is taken.
// Reset clears control state, order error and config registers; grid RAM contents undefined.
module grid_interpolation_weights_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          mode,
    input  logic [gi_pkg::IDX_W-1:0]      point_index,
    input  logic signed [gi_pkg::COORD_W-1:0] coord,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [gi_pkg::IDX_W-1:0]      left_index,
    output logic [gi_pkg::IDX_W-1:0]      right_index,
    output logic [gi_pkg::WEIGHT_W-1:0]   weight,
    output logic                          status,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gi_pkg::PADDR_W-1:0]    paddr,
    input  logic [gi_pkg::PDATA_W-1:0]    pwdata,
    output logic [gi_pkg::PDATA_W-1:0]    prdata,
    output logic                          pready
);

    import gi_pkg::*;

    state_t                    state_reg, state_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic signed [COORD_W-1:0] x_reg, x_next;
    logic [COUNT_W-1:0]        lo_reg, lo_next;
    logic [COUNT_W-1:0]        hi_reg, hi_next;
    logic [COUNT_W-1:0]        n_reg, n_next;
    logic signed [COORD_W-1:0] xl_reg, xl_next;
    logic [IDX_W-1:0]          res_left_reg, res_left_next;
    logic [IDX_W-1:0]          res_right_reg, res_right_next;
    logic [WEIGHT_W-1:0]       res_weight_reg, res_weight_next;
    logic                      res_status_reg, res_status_next;
    logic                      order_error_reg, order_error_next;
    logic [1:0]                interp_mode_reg;
    logic [COUNT_W-1:0]        grid_count_reg;
    logic                      out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]          left_index_reg, left_index_next;
    logic [IDX_W-1:0]          right_index_reg, right_index_next;
    logic [WEIGHT_W-1:0]       weight_reg, weight_next;
    logic                      status_reg, status_next;

    logic                      in_take;
    logic                      cfg_write;
    logic                      ram_we;
    logic [IDX_W-1:0]          ram_raddr;
    logic [COORD_W-1:0]        ram_rdata;
    logic signed [COORD_W-1:0] grid_val;
    logic [COUNT_W-1:0]        n_cfg;
    logic [COUNT_W:0]          mid_sum;
    logic [COUNT_W-1:0]        mid;
    logic                      go_left;
    logic [COUNT_W-1:0]        sr_lo_new, sr_hi_new;
    logic                      sr_more;
    logic                      has_right;
    logic                      in_span;
    logic [COORD_W:0]          num_w, den_w;
    logic                      near_up;
    logic                      ld_bad;
    logic                      out_free;
    div_word_t                 chain_w [FRAC_BITS+1];

    assign in_take   = in_valid && !in_stall;
    assign in_stall  = state_reg != ST_IDLE;
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_INTERP_MODE) ? PDATA_W'(interp_mode_reg)
                                                     : PDATA_W'(grid_count_reg);

    assign grid_val  = $signed(ram_rdata);
    assign n_cfg     = (grid_count_reg > COUNT_MAX) ? COUNT_MAX : grid_count_reg;
    assign mid_sum   = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid       = mid_sum[COUNT_W:1];
    assign go_left   = grid_val > x_reg;
    assign sr_lo_new = go_left ? lo_reg : mid;
    assign sr_hi_new = go_left ? mid : hi_reg;
    assign sr_more   = {1'b0, sr_hi_new} > ({1'b0, sr_lo_new} + (COUNT_W+1)'(1));
    assign has_right = ({1'b0, lo_reg} + (COUNT_W+1)'(1)) < {1'b0, n_reg};
    assign in_span   = (x_reg >= xl_reg) && has_right;
    assign num_w     = {x_reg[COORD_W-1], x_reg} - {xl_reg[COORD_W-1], xl_reg};
    assign den_w     = {grid_val[COORD_W-1], grid_val} - {xl_reg[COORD_W-1], xl_reg};
    assign near_up   = {num_w[COORD_W-1:0], 1'b0} > {1'b0, den_w[COORD_W-1:0]};
    assign ld_bad    = (idx_reg != '0) && (grid_val >= x_reg);
    assign out_free  = !out_valid_reg || !out_stall;

    gi_ram #(
        .WIDTH (COORD_W),
        .DEPTH (GRID_POINTS)
    ) u_grid (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (x_reg),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        chain_w[0].valid = state_reg == ST_EVAL && interp_mode_reg != INTERP_PWC
                           && interp_mode_reg != INTERP_NEAREST && in_span;
        chain_w[0].rem   = num_w[COORD_W-1:0];
        chain_w[0].den   = den_w[COORD_W-1:0];
        chain_w[0].quo   = '0;
    end

    for (genvar k = 0; k < FRAC_BITS; k++)
    begin : g_div
        gi_div_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .din   (chain_w[k]),
            .dout  (chain_w[k+1])
        );
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    state_next = (mode == OP_QUERY) ? ST_Q_START : ST_LD_READ;
                end
            end
            ST_LD_READ:  state_next = ST_LD_CHECK;
            ST_LD_CHECK: state_next = ST_DONE;
            ST_Q_START:
            begin
                if (n_cfg < COUNT_W'(2) || order_error_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_SR_ADDR;
                end
            end
            ST_SR_ADDR:  state_next = ST_SR_CMP;
            ST_SR_CMP:   state_next = sr_more ? ST_SR_ADDR : ST_RD_LEFT;
            ST_RD_LEFT:  state_next = ST_RD_RIGHT;
            ST_RD_RIGHT: state_next = ST_EVAL;
            ST_EVAL:     state_next = chain_w[0].valid ? ST_DIV : ST_DONE;
            ST_DIV:
            begin
                if (chain_w[FRAC_BITS].valid)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:     state_next = ST_IDLE;
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        idx_next         = idx_reg;
        x_next           = x_reg;
        lo_next          = lo_reg;
        hi_next          = hi_reg;
        n_next           = n_reg;
        xl_next          = xl_reg;
        res_left_next    = res_left_reg;
        res_right_next   = res_right_reg;
        res_weight_next  = res_weight_reg;
        res_status_next  = res_status_reg;
        order_error_next = order_error_reg;
        ram_we           = 1'b0;
        ram_raddr        = mid[IDX_W-1:0];
        out_valid_next   = out_valid_reg && out_stall;
        left_index_next  = left_index_reg;
        right_index_next = right_index_reg;
        weight_next      = weight_reg;
        status_next      = status_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    idx_next  = point_index;
                    x_next    = coord;
                end
            end
            ST_LD_READ:
            begin
                ram_raddr = idx_reg - IDX_W'(1);
            end
            ST_LD_CHECK:
            begin
                ram_we           = 1'b1;
                order_error_next = order_error_reg || ld_bad;
                res_left_next    = '0;
                res_right_next   = '0;
                res_weight_next  = '0;
                res_status_next  = order_error_reg || ld_bad;
            end
            ST_Q_START:
            begin
                n_next          = n_cfg;
                lo_next         = '0;
                hi_next         = n_cfg;
                res_left_next   = '0;
                res_right_next  = '0;
                res_weight_next = '0;
                res_status_next = (n_cfg >= COUNT_W'(2)) && order_error_reg;
            end
            ST_SR_CMP:
            begin
                lo_next = sr_lo_new;
                hi_next = sr_hi_new;
            end
            ST_RD_LEFT:
            begin
                ram_raddr = lo_reg[IDX_W-1:0];
            end
            ST_RD_RIGHT:
            begin
                ram_raddr = lo_reg[IDX_W-1:0] + IDX_W'(1);
                xl_next   = grid_val;
            end
            ST_EVAL:
            begin
                res_left_next   = lo_reg[IDX_W-1:0];
                res_right_next  = lo_reg[IDX_W-1:0];
                res_weight_next = '0;
                res_status_next = 1'b0;
                if (interp_mode_reg != INTERP_PWC && in_span)
                begin
                    res_right_next = lo_reg[IDX_W-1:0] + IDX_W'(1);
                    if (interp_mode_reg == INTERP_NEAREST && near_up)
                    begin
                        res_weight_next = WEIGHT_ONE;
                    end
                end
            end
            ST_DIV:
            begin
                if (chain_w[FRAC_BITS].valid)
                begin
                    res_weight_next = WEIGHT_W'(chain_w[FRAC_BITS].quo);
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    left_index_next  = res_left_reg;
                    right_index_next = res_right_reg;
                    weight_next      = res_weight_reg;
                    status_next      = res_status_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            order_error_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            interp_mode_reg <= INTERP_LINEAR;
            grid_count_reg  <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            order_error_reg <= order_error_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_write)
            begin
                if (paddr[2] == REG_INTERP_MODE)
                begin
                    interp_mode_reg <= pwdata[1:0];
                end
                else
                begin
                    grid_count_reg <= pwdata[COUNT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg         <= idx_next;
        x_reg           <= x_next;
        lo_reg          <= lo_next;
        hi_reg          <= hi_next;
        n_reg           <= n_next;
        xl_reg          <= xl_next;
        res_left_reg    <= res_left_next;
        res_right_reg   <= res_right_next;
        res_weight_reg  <= res_weight_next;
        res_status_reg  <= res_status_next;
        left_index_reg  <= left_index_next;
        right_index_reg <= right_index_next;
        weight_reg      <= weight_next;
        status_reg      <= status_next;
    end

    assign out_valid   = out_valid_reg;
    assign left_index  = left_index_reg;
    assign right_index = right_index_reg;
    assign weight      = weight_reg;
    assign status      = status_reg;

endmodule

// File: src/gi_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
module gi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: src/gi_div_cell.sv
`timescale 1ns / 1ps
// One restoring-division cell: produces one quotient bit and passes the word on.
module gi_div_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  gi_pkg::div_word_t din,
    output gi_pkg::div_word_t dout
);

    import gi_pkg::*;

    logic              valid_reg;
    div_word_t         word_reg;
    div_word_t         word_next;
    logic [COORD_W:0]  rem_shift;
    logic [COORD_W:0]  den_ext;
    logic [COORD_W:0]  rem_sub;
    logic              take;

    assign rem_shift = {din.rem, 1'b0};
    assign den_ext   = {1'b0, din.den};
    assign take      = rem_shift >= den_ext;
    assign rem_sub   = rem_shift - den_ext;

    always_comb
    begin
        word_next.valid = din.valid;
        word_next.den   = din.den;
        word_next.rem   = take ? rem_sub[COORD_W-1:0] : rem_shift[COORD_W-1:0];
        word_next.quo   = {din.quo[FRAC_BITS-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= din.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    always_comb
    begin
        dout       = word_reg;
        dout.valid = valid_reg;
    end

endmodule
